### rtl/irpdt_pkg.sv
package irpdt_pkg;

  // counter width default
  localparam int unsigned CountWidthDef = 20;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_MARK_TICKS         = 3'd0;
  localparam logic [2:0] CFG_ONE_SPACE_TICKS    = 3'd1;
  localparam logic [2:0] CFG_LEADER_MARK_TICKS  = 3'd2;
  localparam logic [2:0] CFG_LEADER_SPACE_TICKS = 3'd3;
  localparam logic [2:0] CFG_TAIL_GAP_TICKS     = 3'd4;

  // register reset values, cut down to the counter width at the point of use
  localparam logic [31:0] RST_MARK_TICKS         = 32'd22500;
  localparam logic [31:0] RST_ONE_SPACE_TICKS    = 32'd67500;
  localparam logic [31:0] RST_LEADER_MARK_TICKS  = 32'd360000;
  localparam logic [31:0] RST_LEADER_SPACE_TICKS = 32'd180000;
  localparam logic [31:0] RST_TAIL_GAP_TICKS     = 32'd1600;

  // frame phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LMARK  = 3'd1;
  localparam logic [2:0] PH_LSPACE = 3'd2;
  localparam logic [2:0] PH_BMARK  = 3'd3;
  localparam logic [2:0] PH_BSPACE = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;
  localparam logic [2:0] PH_GAP    = 3'd6;

  // bits in one frame
  localparam logic [5:0] FRAME_BITS = 6'd32;

  // one result transaction
  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic carrier_enable;
  } result_t;

endpackage

### rtl/ir_pulse_distance_transmitter_core.sv
// channel   | direction | payload
// s_axis    | in        | tuser: start_req; tdata: device_address, command_byte
// m_axis    | out       | tdata: carrier_enable, busy_res, frame_done, zero pad
// cfg       | in        | write enable, register index, COUNT_WIDTH-bit tick count
//
// One input transaction is one timing tick and yields one result transaction.
// A transaction is accepted every cycle: the frame state (phase, tick counter,
// shift register, bit count) steps in the cycle of acceptance and the result
// goes into a two-entry output stage, so s_axis_tready drops only when both
// entries hold results the downstream side has not taken.
// Reset clears the frame state to idle and loads the default tick counts.
module ir_pulse_distance_transmitter_core
  import irpdt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // [7:0] device_address, [15:8] command_byte
  input  logic                   s_axis_tuser,   // [0] start_req
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [0] carrier_enable, [1] busy_res,
                                                 // [2] frame_done, [7:3] zero
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [COUNT_WIDTH-1:0] cfg_data_i
);

  // configuration registers
  logic [COUNT_WIDTH-1:0] mark_q, one_space_q, lead_mark_q, lead_space_q, tail_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q       <= RST_MARK_TICKS[COUNT_WIDTH-1:0];
      one_space_q  <= RST_ONE_SPACE_TICKS[COUNT_WIDTH-1:0];
      lead_mark_q  <= RST_LEADER_MARK_TICKS[COUNT_WIDTH-1:0];
      lead_space_q <= RST_LEADER_SPACE_TICKS[COUNT_WIDTH-1:0];
      tail_gap_q   <= RST_TAIL_GAP_TICKS[COUNT_WIDTH-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MARK_TICKS:         mark_q       <= cfg_data_i;
        CFG_ONE_SPACE_TICKS:    one_space_q  <= cfg_data_i;
        CFG_LEADER_MARK_TICKS:  lead_mark_q  <= cfg_data_i;
        CFG_LEADER_SPACE_TICKS: lead_space_q <= cfg_data_i;
        CFG_TAIL_GAP_TICKS:     tail_gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state
  logic [2:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [31:0]            shift_q, shift_d;
  logic [5:0]             bits_q, bits_d;

  // effective state for this tick, after a possible start
  logic [2:0]             cur_phase;
  logic [COUNT_WIDTH-1:0] cur_tick;
  logic [31:0]            cur_shift;
  logic [5:0]             cur_bits;
  logic                   run;
  logic [7:0]             addr, cmd;

  assign addr = s_axis_tdata[7:0];
  assign cmd  = s_axis_tdata[15:8];

  always_comb begin
    cur_phase = phase_q;
    cur_tick  = tick_q;
    cur_shift = shift_q;
    cur_bits  = bits_q;
    run       = 1'b1;
    // unused phase codes count as idle
    if (phase_q == PH_IDLE || phase_q > PH_GAP) begin
      cur_phase = PH_IDLE;
      if (!s_axis_tuser) begin
        run = 1'b0;
      end else begin
        cur_phase = PH_LMARK;
        cur_tick  = '0;
        cur_shift = {addr, ~addr, cmd, ~cmd};
        cur_bits  = FRAME_BITS;
      end
    end
  end

  // length of the current phase, zero acts as one tick
  logic [COUNT_WIDTH-1:0] dur, dur_eff;
  logic                   last_tick;

  always_comb begin
    case (cur_phase)
      PH_LMARK:  dur = lead_mark_q;
      PH_LSPACE: dur = lead_space_q;
      PH_BSPACE: dur = cur_shift[31] ? one_space_q : mark_q;
      PH_GAP:    dur = tail_gap_q;
      default:   dur = mark_q;
    endcase
    dur_eff   = (dur == '0) ? COUNT_WIDTH'(1) : dur;
    last_tick = ({1'b0, cur_tick} + (COUNT_WIDTH + 1)'(1)) >= {1'b0, dur_eff};
  end

  // next state and result
  result_t res;

  always_comb begin
    phase_d = cur_phase;
    tick_d  = cur_tick;
    shift_d = cur_shift;
    bits_d  = cur_bits;
    res     = '0;
    if (run) begin
      res.busy_res       = 1'b1;
      res.carrier_enable = (cur_phase == PH_LMARK) || (cur_phase == PH_BMARK) ||
                           (cur_phase == PH_STOP);
      if (last_tick) begin
        tick_d = '0;
        unique case (cur_phase)
          PH_LMARK:  phase_d = PH_LSPACE;
          PH_LSPACE: phase_d = PH_BMARK;
          PH_BMARK:  phase_d = PH_BSPACE;
          PH_BSPACE: begin
            shift_d = {cur_shift[30:0], 1'b0};
            if (cur_bits <= 6'd1) begin
              bits_d  = '0;
              phase_d = PH_STOP;
            end else begin
              bits_d  = cur_bits - 6'd1;
              phase_d = PH_BMARK;
            end
          end
          PH_STOP:   phase_d = PH_GAP;
          default: begin
            phase_d        = PH_IDLE;
            res.frame_done = 1'b1;
          end
        endcase
      end else begin
        tick_d = cur_tick + COUNT_WIDTH'(1);
      end
    end
  end

  // two-entry output stage
  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    accept, pop;

  assign s_axis_tready = !skid_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      shift_q  <= '0;
      bits_q   <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      // frame state steps on every accepted transaction
      if (accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        shift_q <= shift_d;
        bits_q  <= bits_d;
      end
      if (!out_v_q || pop) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= accept;
        end
      end else if (accept) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_q.frame_done, out_q.busy_res, out_q.carrier_enable};

endmodule
